FILE: hw/rtl/fpalu_pkg.sv
// Shared types and mode codes for the fixed-point ALU.
`default_nettype none
package fpalu_pkg;
   typedef enum logic [3:0] {
      MODE_ADD = 4'd0, MODE_SUB = 4'd1, MODE_MUL = 4'd2, MODE_DIV = 4'd3,
      MODE_LT = 4'd4, MODE_GT = 4'd5, MODE_LE = 4'd6, MODE_GE = 4'd7,
      MODE_EQ = 4'd8, MODE_NE = 4'd9, MODE_MIN = 4'd10, MODE_MAX = 4'd11,
      MODE_INC = 4'd12, MODE_DEC = 4'd13, MODE_TO_INT = 4'd14, MODE_FROM_INT = 4'd15
   } mode_type;

   typedef enum logic [1:0] {
      ERR_OK = 2'd0, ERR_OVERFLOW = 2'd1, ERR_DIV_ZERO = 2'd2
   } err_type;
endpackage
`default_nettype wire

FILE: hw/rtl/fixed_point_alu_q24_8_top.sv
// Top level of the pipelined signed fixed-point ALU.
//
//   channel  direction  ports
//   req      in         req_valid req_ready req_mode req_operand_a req_operand_b
//   rsp      out        rsp_valid rsp_ready rsp_result_value rsp_compare_true
//                       rsp_error_code
//
// One word enters per cycle unless stalled. Stages: decode, restoring divider
// (one quotient bit each), rounding, output register; every mode travels that
// same pipe so results leave in order. A stall freezes the whole pipe and the
// output register; req_ready is high whenever the output register is free or
// being drained. Reset clears only the valid bits.
`default_nettype none
module fixed_point_alu_q24_8_top #(
   parameter int FRACTION_BITS = 8,
   parameter int DATA_WIDTH = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [3:0]                   req_mode,
   input  wire  signed [DATA_WIDTH-1:0] req_operand_a,
   input  wire  signed [DATA_WIDTH-1:0] req_operand_b,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_result_value,
   output logic                         rsp_compare_true,
   output logic [1:0]                   rsp_error_code
);
   localparam int W = DATA_WIDTH;
   localparam int F = FRACTION_BITS;
   localparam int NQ = W + F;
   localparam int NS = NQ;
   localparam int PW = 2 * W;

   localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic [3:0]   mode;
      logic         neg;
      logic [W-1:0] res;
      logic         cmp;
      logic [1:0]   err;
      logic [PW-1:0] prod;
      logic [W-1:0] mb;
      logic [W:0]   rem;
      logic [NQ-1:0] quo;
   } stage_type;

   logic advance;
   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage 0: decode, simple modes, magnitudes
   stage_type s0_in, s0_ff;
   logic      v0_ff;
   logic [W-1:0] a, b, ma, mb;
   logic an, bn, lt_ab, lt_ba;
   logic [W-1:0] sum, dif;

   always_comb begin
      a = req_operand_a;
      b = req_operand_b;
      an = a[W-1];
      bn = b[W-1];
      ma = an ? (~a + 1'b1) : a;
      mb = bn ? (~b + 1'b1) : b;
      lt_ab = $signed(a) < $signed(b);
      lt_ba = $signed(b) < $signed(a);
      sum = a + b;
      dif = a - b;
      s0_in = '0;
      s0_in.mode = req_mode;
      s0_in.neg = an ^ bn;
      s0_in.mb = mb;
      s0_in.quo = {ma, {F{1'b0}}};
      s0_in.err = fpalu_pkg::ERR_OK;
      unique case (fpalu_pkg::mode_type'(req_mode))
         fpalu_pkg::MODE_ADD: begin
            s0_in.res = sum;
            if (an == bn && sum[W-1] != an) begin
               s0_in.res = an ? MINN : MAXP;
               s0_in.err = fpalu_pkg::ERR_OVERFLOW;
            end
         end
         fpalu_pkg::MODE_SUB: begin
            s0_in.res = dif;
            if (an != bn && dif[W-1] != an) begin
               s0_in.res = an ? MINN : MAXP;
               s0_in.err = fpalu_pkg::ERR_OVERFLOW;
            end
         end
         fpalu_pkg::MODE_MUL: s0_in.prod = ma * mb;
         fpalu_pkg::MODE_DIV: begin
            if (b == '0) s0_in.err = fpalu_pkg::ERR_DIV_ZERO;
         end
         fpalu_pkg::MODE_LT: s0_in.cmp = lt_ab;
         fpalu_pkg::MODE_GT: s0_in.cmp = lt_ba;
         fpalu_pkg::MODE_LE: s0_in.cmp = !lt_ba;
         fpalu_pkg::MODE_GE: s0_in.cmp = !lt_ab;
         fpalu_pkg::MODE_EQ: s0_in.cmp = a == b;
         fpalu_pkg::MODE_NE: s0_in.cmp = a != b;
         fpalu_pkg::MODE_MIN: s0_in.res = lt_ab ? a : b;
         fpalu_pkg::MODE_MAX: s0_in.res = lt_ba ? a : b;
         fpalu_pkg::MODE_INC: begin
            if (a == MAXP) begin
               s0_in.res = MAXP;
               s0_in.err = fpalu_pkg::ERR_OVERFLOW;
            end else s0_in.res = a + 1'b1;
         end
         fpalu_pkg::MODE_DEC: begin
            if (a == MINN) begin
               s0_in.res = MINN;
               s0_in.err = fpalu_pkg::ERR_OVERFLOW;
            end else s0_in.res = a - 1'b1;
         end
         fpalu_pkg::MODE_TO_INT: begin
            s0_in.res = an ? ~(ma >> F) + 1'b1 : (ma >> F);
         end
         fpalu_pkg::MODE_FROM_INT: begin
            if (an ? (ma > (MINN >> F)) : (ma > (MAXP >> F))) begin
               s0_in.res = an ? MINN : MAXP;
               s0_in.err = fpalu_pkg::ERR_OVERFLOW;
            end else s0_in.res = a << F;
         end
         default: s0_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (advance) v0_ff <= req_valid;
      if (advance) s0_ff <= s0_in;
   end

   // divider stages, one quotient bit each
   stage_type st_ff [NS];
   logic      vs_ff [NS];
   stage_type st_in [NS];

   for (genvar i = 0; i < NS; i++) begin : g_div
      always_comb begin
         stage_type p;
         logic [W+1:0] sh;
         logic [W+1:0] tr;
         p = (i == 0) ? s0_ff : st_ff[(i == 0) ? 0 : i-1];
         st_in[i] = p;
         sh = {p.rem, p.quo[NQ-1]};
         tr = sh - {2'b00, p.mb};
         if (!tr[W+1]) begin
            st_in[i].rem = tr[W:0];
            st_in[i].quo = {p.quo[NQ-2:0], 1'b1};
         end else begin
            st_in[i].rem = sh[W:0];
            st_in[i].quo = {p.quo[NQ-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) vs_ff[i] <= 1'b0;
         else if (advance) vs_ff[i] <= (i == 0) ? v0_ff : vs_ff[(i == 0) ? 0 : i-1];
         if (advance) st_ff[i] <= st_in[i];
      end
   end

   // rounding stage
   stage_type r_in, r_ff;
   logic      vr_ff;
   logic [NQ:0] qr;
   logic [PW:0] pr;
   logic [W:0]  rem2;
   logic [W:0]  mb1;

   always_comb begin
      r_in = st_ff[NS-1];
      mb1 = {1'b0, r_in.mb};
      rem2 = r_in.rem;
      qr = {1'b0, r_in.quo} + ((rem2 >= mb1 - rem2) ? 1'b1 : 1'b0);
      pr = ({1'b0, r_in.prod} + (PW+1)'(1 << (F-1))) >> F;
      if (fpalu_pkg::mode_type'(r_in.mode) == fpalu_pkg::MODE_MUL)
         r_in.quo = '0;
      r_in.prod = pr[PW-1:0];
      r_in.rem = '0;
      if (fpalu_pkg::mode_type'(r_in.mode) == fpalu_pkg::MODE_DIV)
         r_in.prod = PW'(qr);
   end

   always_ff @(posedge clock) begin
      if (reset) vr_ff <= 1'b0;
      else if (advance) vr_ff <= vs_ff[NS-1];
      if (advance) r_ff <= r_in;
   end

   // pack, saturate, output register
   logic [W-1:0] res_out;
   logic [1:0]   err_out;
   logic [W-1:0] lim;
   logic [PW-1:0] m;

   always_comb begin
      res_out = r_ff.res;
      err_out = r_ff.err;
      m = r_ff.prod;
      lim = r_ff.neg ? MINN : MAXP;
      if ((fpalu_pkg::mode_type'(r_ff.mode) == fpalu_pkg::MODE_MUL ||
           fpalu_pkg::mode_type'(r_ff.mode) == fpalu_pkg::MODE_DIV) &&
          r_ff.err != fpalu_pkg::ERR_DIV_ZERO) begin
         if (m > {{W{1'b0}}, lim}) begin
            res_out = lim;
            err_out = fpalu_pkg::ERR_OVERFLOW;
         end else res_out = r_ff.neg ? ~m[W-1:0] + 1'b1 : m[W-1:0];
      end else if (r_ff.err == fpalu_pkg::ERR_DIV_ZERO) res_out = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (advance) rsp_valid <= vr_ff;
      if (advance) begin
         rsp_result_value <= res_out;
         rsp_compare_true <= r_ff.cmp;
         rsp_error_code   <= err_out;
      end
   end
endmodule
`default_nettype wire
